// File: design/montgomery_modular_exponentiation_assert.svh
// Assertion helpers shared by the RTL modules.
// Each macro expects clk and arst_n to be visible in the enclosing module.
`ifndef MONTGOMERY_MODULAR_EXPONENTIATION_ASSERT_SVH
`define MONTGOMERY_MODULAR_EXPONENTIATION_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MME_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define MME_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: design/mme_pkg.sv
package mme_pkg;

	// Datapath width of modulus, operands and result
	localparam int OPERAND_WIDTH = 32;
	// Width of the iteration count register
	localparam int BITS_WIDTH = 6;
	// Width of the configuration register index
	localparam int CFG_INDEX_WIDTH = 2;

	// Configuration register indexes
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_MODULUS      = 2'd0;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_MODULUS_BITS = 2'd1;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_R_SQUARED    = 2'd2;

	// Montgomery multiplier sequencer
	typedef enum logic [1:0] {
		MM_IDLE,
		MM_ITER,
		MM_FINAL
	} mm_state_t;

	// Exponentiation sequencer
	typedef enum logic [2:0] {
		PH_IDLE,
		PH_PRE_P,
		PH_PRE_S,
		PH_MUL,
		PH_SQR,
		PH_POST,
		PH_OUT
	} phase_t;

	// Request from sequencer to multiplier
	typedef struct packed {
		logic                     start;
		logic [OPERAND_WIDTH-1:0] a;
		logic [OPERAND_WIDTH-1:0] b;
		logic [OPERAND_WIDTH-1:0] n;
		logic [BITS_WIDTH-1:0]    iters;
	} mm_req_t;

	// Response from multiplier
	typedef struct packed {
		logic                     done;
		logic [OPERAND_WIDTH-1:0] res;
	} mm_rsp_t;

endpackage

// File: design/mme_if.sv
// Operand channel: base and exponent
interface mme_in_if;
	logic                                valid;
	logic                                ready;
	logic [mme_pkg::OPERAND_WIDTH-1:0]   base_value;
	logic [mme_pkg::OPERAND_WIDTH-1:0]   exponent_value;

	modport source (output valid, output base_value, output exponent_value, input ready);
	modport sink (input valid, input base_value, input exponent_value, output ready);
endinterface

// Result channel
interface mme_out_if;
	logic                                valid;
	logic                                ready;
	logic [mme_pkg::OPERAND_WIDTH-1:0]   power_result;

	modport source (output valid, output power_result, input ready);
	modport sink (input valid, input power_result, output ready);
endinterface

// Configuration write channel
interface mme_cfg_if;
	logic                                 valid;
	logic                                 ready;
	logic [mme_pkg::CFG_INDEX_WIDTH-1:0]  index;
	logic [mme_pkg::OPERAND_WIDTH-1:0]    data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// File: design/mme_mont_mul.sv
`include "montgomery_modular_exponentiation_assert.svh"

// Radix-2 Montgomery multiplier: one bit of a per cycle.
module mme_mont_mul (
	input  logic             clk,
	input  logic             arst_n,
	input  mme_pkg::mm_req_t req,
	output mme_pkg::mm_rsp_t rsp
);
	localparam int W  = mme_pkg::OPERAND_WIDTH;
	localparam int BW = mme_pkg::BITS_WIDTH;

	mme_pkg::mm_state_t state_q, state_d;

	logic [W-1:0]  a_q;
	logic [W-1:0]  b_q;
	logic [W:0]    bn_q;
	logic [W:0]    t_q;
	logic [BW-1:0] cnt_q;

	logic          abit;
	logic          odd;
	logic [W:0]    addend;
	logic [W+1:0]  sum;
	logic [W+1:0]  diff;

	// One iteration: add b when the a bit is set, add n when odd, halve.
	// b+n is precomputed so only one adder sits in the loop.
	always_comb begin
		abit = a_q[0];
		odd  = t_q[0] ^ (abit & b_q[0]);
		if (abit) begin
			addend = odd ? bn_q : {1'b0, b_q};
		end else begin
			addend = odd ? {1'b0, req.n} : '0;
		end
		sum  = {1'b0, t_q} + {1'b0, addend};
		diff = {1'b0, t_q} - {2'b00, req.n};
	end

	// Sequencer next state and response
	always_comb begin
		state_d  = state_q;
		rsp.done = 1'b0;
		// final conditional subtract
		rsp.res  = diff[W+1] ? t_q[W-1:0] : diff[W-1:0];
		case (state_q)
			mme_pkg::MM_IDLE: begin
				if (req.start) begin
					state_d = (req.iters == '0) ? mme_pkg::MM_FINAL : mme_pkg::MM_ITER;
				end
			end
			mme_pkg::MM_ITER: begin
				if (cnt_q == BW'(1)) begin
					state_d = mme_pkg::MM_FINAL;
				end
			end
			mme_pkg::MM_FINAL: begin
				rsp.done = 1'b1;
				state_d  = mme_pkg::MM_IDLE;
			end
			default: begin
				state_d = mme_pkg::MM_IDLE;
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mme_pkg::MM_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == mme_pkg::MM_IDLE && req.start) begin
				cnt_q <= req.iters;
			end else if (state_q == mme_pkg::MM_ITER) begin
				cnt_q <= cnt_q - BW'(1);
			end
		end
	end

	// Operand shift register and accumulator
	always_ff @(posedge clk) begin
		if (state_q == mme_pkg::MM_IDLE && req.start) begin
			a_q  <= req.a;
			b_q  <= req.b;
			bn_q <= {1'b0, req.b} + {1'b0, req.n};
			t_q  <= '0;
		end else if (state_q == mme_pkg::MM_ITER) begin
			a_q <= a_q >> 1;
			t_q <= sum[W+1:1];
		end
	end

	`MME_ASSERT_SAME(a_start_when_idle, req.start, state_q == mme_pkg::MM_IDLE, "start while product busy")
	`MME_ASSERT_SAME(a_iter_count_live, state_q == mme_pkg::MM_ITER, cnt_q != '0, "iteration with zero count")
	`MME_ASSERT_NEXT(a_iter_count_step, state_q == mme_pkg::MM_ITER && cnt_q != BW'(1), state_q == mme_pkg::MM_ITER && cnt_q == $past(cnt_q) - BW'(1), "iteration count did not step")

endmodule

// File: design/montgomery_modular_exponentiation.sv
// Modular exponentiation, power_result = base_value ^ exponent_value mod modulus, by
// right-to-left square-and-multiply over one shared radix-2 Montgomery multiplier that
// consumes one operand bit per cycle. Program modulus (odd), modulus_bits (its bit length)
// and r_squared_mod_n (2^(2*modulus_bits) mod modulus) while idle; base_value should be
// below modulus. An item takes 3 + popcount(e) + (bit length of e minus one, zero for e = 0)
// Montgomery products. One item is in flight at a time; a finished result sits in an output
// register, so the next item is accepted while it waits to be taken. No clearing pass follows
// reset.
`include "montgomery_modular_exponentiation_assert.svh"

module montgomery_modular_exponentiation (
	input  logic         clk,
	input  logic         arst_n,
	mme_cfg_if.sink      cfg,
	mme_in_if.sink       operands,
	mme_out_if.source    power
);
	localparam int W  = mme_pkg::OPERAND_WIDTH;
	localparam int BW = mme_pkg::BITS_WIDTH;

	// Configuration
	logic [W-1:0]  mod_q;
	logic [BW-1:0] bits_q;
	logic [W-1:0]  r2_q;

	// Sequencer and working registers
	mme_pkg::phase_t phase_q, phase_d;
	logic            busy_q;
	logic [W-1:0]    prod_q;
	logic [W-1:0]    sq_q;
	logic [W-1:0]    exp_q;
	logic [W-1:0]    res_q;
	logic            out_valid_q;

	logic            in_take;
	logic            out_load;
	logic            prod_phase;

	mme_pkg::mm_req_t mm_req;
	mme_pkg::mm_rsp_t mm_rsp;

	mme_mont_mul u_mont_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mm_req),
		.rsp    (mm_rsp)
	);

	// Configuration writes, always ready
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mod_q  <= W'(1);
			bits_q <= BW'(32);
			r2_q   <= '0;
		end else if (cfg.valid) begin
			case (cfg.index)
				mme_pkg::REG_MODULUS:      mod_q  <= cfg.data;
				mme_pkg::REG_MODULUS_BITS: bits_q <= cfg.data[BW-1:0];
				mme_pkg::REG_R_SQUARED:    r2_q   <= cfg.data;
				default: ;
			endcase
		end
	end

	// Handshakes
	assign operands.ready     = (phase_q == mme_pkg::PH_IDLE);
	assign in_take            = operands.valid && operands.ready;
	assign out_load           = (phase_q == mme_pkg::PH_OUT) && (!out_valid_q || power.ready);
	assign power.valid        = out_valid_q;
	assign power.power_result = res_q;

	assign prod_phase = (phase_q == mme_pkg::PH_PRE_P) || (phase_q == mme_pkg::PH_PRE_S) ||
		(phase_q == mme_pkg::PH_MUL) || (phase_q == mme_pkg::PH_SQR) ||
		(phase_q == mme_pkg::PH_POST);

	// Multiplier operand select and next phase
	always_comb begin
		phase_d      = phase_q;
		mm_req.start = prod_phase && !busy_q;
		mm_req.n     = mod_q;
		mm_req.iters = bits_q;
		mm_req.a     = prod_q;
		mm_req.b     = sq_q;
		case (phase_q)
			mme_pkg::PH_IDLE: begin
				if (in_take) begin
					phase_d = mme_pkg::PH_PRE_P;
				end
			end
			mme_pkg::PH_PRE_P: begin
				// one into the Montgomery domain
				mm_req.a = W'(1);
				mm_req.b = r2_q;
				if (mm_rsp.done) begin
					phase_d = mme_pkg::PH_PRE_S;
				end
			end
			mme_pkg::PH_PRE_S: begin
				// base (held in sq_q) into the Montgomery domain
				mm_req.a = sq_q;
				mm_req.b = r2_q;
				if (mm_rsp.done) begin
					if (exp_q == '0) begin
						phase_d = mme_pkg::PH_POST;
					end else if (exp_q[0]) begin
						phase_d = mme_pkg::PH_MUL;
					end else begin
						phase_d = mme_pkg::PH_SQR;
					end
				end
			end
			mme_pkg::PH_MUL: begin
				if (mm_rsp.done) begin
					// skip the square when no exponent bits remain
					phase_d = (exp_q[W-1:1] == '0) ? mme_pkg::PH_POST : mme_pkg::PH_SQR;
				end
			end
			mme_pkg::PH_SQR: begin
				mm_req.a = sq_q;
				if (mm_rsp.done) begin
					phase_d = exp_q[1] ? mme_pkg::PH_MUL : mme_pkg::PH_SQR;
				end
			end
			mme_pkg::PH_POST: begin
				// leave the Montgomery domain
				mm_req.b = W'(1);
				if (mm_rsp.done) begin
					phase_d = mme_pkg::PH_OUT;
				end
			end
			mme_pkg::PH_OUT: begin
				if (out_load) begin
					phase_d = mme_pkg::PH_IDLE;
				end
			end
			default: begin
				phase_d = mme_pkg::PH_IDLE;
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= mme_pkg::PH_IDLE;
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			phase_q <= phase_d;
			if (mm_req.start) begin
				busy_q <= 1'b1;
			end else if (mm_rsp.done) begin
				busy_q <= 1'b0;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (power.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Working registers and result register
	always_ff @(posedge clk) begin
		if (in_take) begin
			sq_q  <= operands.base_value;
			exp_q <= operands.exponent_value;
		end
		if (mm_rsp.done) begin
			case (phase_q)
				mme_pkg::PH_PRE_P: prod_q <= mm_rsp.res;
				mme_pkg::PH_PRE_S: sq_q   <= mm_rsp.res;
				mme_pkg::PH_MUL:   prod_q <= mm_rsp.res;
				mme_pkg::PH_SQR: begin
					sq_q  <= mm_rsp.res;
					exp_q <= exp_q >> 1;
				end
				mme_pkg::PH_POST:  prod_q <= mm_rsp.res;
				default: ;
			endcase
		end
		if (out_load) begin
			res_q <= prod_q;
		end
	end

	`MME_ASSERT_NEXT(a_take_starts_item, in_take, phase_q == mme_pkg::PH_PRE_P, "accepted item did not start")
	`MME_ASSERT_SAME(a_done_when_busy, mm_rsp.done, busy_q && prod_phase, "product done with none issued")
	`MME_ASSERT_NEXT(a_result_loaded, phase_q == mme_pkg::PH_OUT && !out_valid_q, out_valid_q && phase_q == mme_pkg::PH_IDLE, "free output register not loaded")

endmodule

// File: tb/montgomery_modular_exponentiation_test.sv
module montgomery_modular_exponentiation_test;
	timeunit 1ns;
	timeprecision 1ps;

	import mme_pkg::*;

	// Index with no register behind it; writes to it must be dropped
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_UNMAPPED = 2'd3;
	localparam int unsigned CYCLE_LIMIT = 4_000_000;
	localparam logic [OPERAND_WIDTH-1:0] ALL_ONES = '1;

	typedef struct {
		logic [OPERAND_WIDTH-1:0] base_value;
		logic [OPERAND_WIDTH-1:0] exponent_value;
	} operand_t;

	logic clk;
	logic arst_n;

	mme_cfg_if cfg_bus();
	mme_in_if operand_bus();
	mme_out_if power_bus();

	montgomery_modular_exponentiation dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_bus),
		.operands (operand_bus),
		.power    (power_bus)
	);

	// Local copy of the register file
	logic [OPERAND_WIDTH-1:0] cfg_modulus;
	logic [BITS_WIDTH-1:0]    cfg_iterations;
	logic [OPERAND_WIDTH-1:0] cfg_r_squared;

	operand_t                 operand_queue[$];
	logic [OPERAND_WIDTH-1:0] expected_powers[$];
	int unsigned              items_open;
	int unsigned              error_count;
	int unsigned              cycle_count;

	int unsigned send_wait;
	int unsigned send_calm;
	int unsigned recv_wait;
	int unsigned recv_calm;
	int unsigned pause;
	operand_t    next_item;
	logic [OPERAND_WIDTH-1:0] want;

	// Clock
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	task automatic report_mismatch(input string msg);
		error_count++;
		$display("ERROR @%0t: %s", $realtime, msg);
	endtask

	// Radix-2 bit-serial Montgomery product with the current register copy
	function automatic logic [OPERAND_WIDTH-1:0] mont_mul(
		input logic [OPERAND_WIDTH-1:0] a,
		input logic [OPERAND_WIDTH-1:0] b
	);
		logic [OPERAND_WIDTH+1:0] acc;
		int k;
		acc = '0;
		for (k = 0; k < int'(cfg_iterations); k++) begin
			if (k < OPERAND_WIDTH && a[k])
				acc += b;
			if (acc[0])
				acc += cfg_modulus;
			acc >>= 1;
		end
		if (acc >= cfg_modulus)
			acc -= cfg_modulus;
		return acc[OPERAND_WIDTH-1:0];
	endfunction

	// Right-to-left square and multiply in the Montgomery domain
	function automatic logic [OPERAND_WIDTH-1:0] predict_power(
		input logic [OPERAND_WIDTH-1:0] base_value,
		input logic [OPERAND_WIDTH-1:0] exponent_value
	);
		logic [OPERAND_WIDTH-1:0] prod;
		logic [OPERAND_WIDTH-1:0] sq;
		logic [OPERAND_WIDTH-1:0] e;
		prod = mont_mul(1, cfg_r_squared);
		sq = mont_mul(base_value, cfg_r_squared);
		e = exponent_value;
		while (e != 0) begin
			if (e[0])
				prod = mont_mul(prod, sq);
			e >>= 1;
			sq = mont_mul(sq, sq);
		end
		return mont_mul(prod, 1);
	endfunction

	// 2^(2*bits) mod n by repeated doubling
	function automatic logic [OPERAND_WIDTH-1:0] r_squared(
		input logic [OPERAND_WIDTH-1:0] n,
		input int unsigned bits
	);
		logic [OPERAND_WIDTH:0] r;
		int unsigned i;
		if (n == 0)
			return '0;
		r = (n == 1) ? '0 : 1;
		for (i = 0; i < 2 * bits; i++) begin
			r = r << 1;
			if (r >= n)
				r -= n;
		end
		return r[OPERAND_WIDTH-1:0];
	endfunction

	// Idle length: mostly none or short, a few long, with calm runs of zero
	function automatic int unsigned idle_length(
		inout int unsigned calm_run,
		input int unsigned long_max
	);
		int unsigned r;
		if (calm_run != 0) begin
			calm_run--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 5) begin
			calm_run = $urandom_range(10, 30);
			return 0;
		end
		if (r < 45)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, long_max);
	endfunction

	task automatic write_register(
		input logic [CFG_INDEX_WIDTH-1:0] idx,
		input logic [OPERAND_WIDTH-1:0] value
	);
		@(posedge clk);
		cfg_bus.valid <= 1'b1;
		cfg_bus.index <= idx;
		cfg_bus.data  <= value;
		do
			@(posedge clk);
		while (!cfg_bus.ready);
		cfg_bus.valid <= 1'b0;
		case (idx)
			REG_MODULUS:      cfg_modulus = value;
			REG_MODULUS_BITS: cfg_iterations = value[BITS_WIDTH-1:0];
			REG_R_SQUARED:    cfg_r_squared = value;
			default: ;
		endcase
	endtask

	task automatic program_setting(
		input logic [OPERAND_WIDTH-1:0] n,
		input int unsigned bits,
		input logic [OPERAND_WIDTH-1:0] r2
	);
		write_register(REG_MODULUS, n);
		write_register(REG_MODULUS_BITS, OPERAND_WIDTH'(bits));
		write_register(REG_R_SQUARED, r2);
	endtask

	task automatic queue_operation(
		input logic [OPERAND_WIDTH-1:0] base_value,
		input logic [OPERAND_WIDTH-1:0] exponent_value
	);
		operand_t item;
		item.base_value = base_value;
		item.exponent_value = exponent_value;
		operand_queue.push_back(item);
		items_open++;
	endtask

	task automatic wait_idle();
		while (items_open != 0)
			@(posedge clk);
	endtask

	// Random setting: mostly a proper odd modulus, sometimes a wrong r squared,
	// an arbitrary iteration count or an even modulus
	task automatic run_random_setting(input int unsigned count);
		logic [63:0] one;
		logic [OPERAND_WIDTH-1:0] n;
		logic [OPERAND_WIDTH-1:0] r2;
		logic [OPERAND_WIDTH-1:0] b;
		int unsigned len;
		int unsigned bits;
		int unsigned pick;
		int unsigned i;
		one = 64'd1;
		len = $urandom_range(2, OPERAND_WIDTH);
		n = ($urandom() | 32'h1) & OPERAND_WIDTH'((one << len) - 1);
		n[len-1] = 1'b1;
		bits = len;
		pick = $urandom_range(0, 9);
		if (pick == 2)
			n[0] = 1'b0;
		r2 = r_squared(n, bits);
		if (pick == 0)
			r2 = $urandom();
		if (pick == 1)
			bits = $urandom_range(0, 63);
		program_setting(n, bits, r2);
		for (i = 0; i < count; i++) begin
			b = ($urandom_range(0, 6) == 0) ? $urandom() : $urandom() % n;
			queue_operation(b, $urandom() >> $urandom_range(0, 32));
		end
		wait_idle();
	endtask

	// Operand driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			operand_bus.valid <= 1'b0;
			operand_bus.base_value <= '0;
			operand_bus.exponent_value <= '0;
			send_wait <= 0;
		end else begin
			if (operand_bus.valid && operand_bus.ready)
				expected_powers.push_back(predict_power(operand_bus.base_value,
					operand_bus.exponent_value));
			if (!operand_bus.valid || operand_bus.ready) begin
				if (send_wait != 0) begin
					operand_bus.valid <= 1'b0;
					send_wait <= send_wait - 1;
				end else if (operand_queue.size() != 0) begin
					next_item = operand_queue.pop_front();
					operand_bus.valid <= 1'b1;
					operand_bus.base_value <= next_item.base_value;
					operand_bus.exponent_value <= next_item.exponent_value;
					send_wait <= idle_length(send_calm, 40);
				end else begin
					operand_bus.valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor and backpressure
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			power_bus.ready <= 1'b0;
			recv_wait <= 0;
		end else begin
			if (power_bus.valid && power_bus.ready) begin
				if (expected_powers.size() == 0) begin
					report_mismatch($sformatf("unexpected power_result %h",
						power_bus.power_result));
				end else begin
					want = expected_powers.pop_front();
					items_open--;
					if (power_bus.power_result !== want)
						report_mismatch($sformatf("power_result %h, expected %h",
							power_bus.power_result, want));
				end
			end
			if (recv_wait != 0) begin
				power_bus.ready <= 1'b0;
				recv_wait <= recv_wait - 1;
			end else if (power_bus.valid && power_bus.ready) begin
				pause = idle_length(recv_calm, 1500);
				power_bus.ready <= (pause == 0);
				recv_wait <= (pause == 0) ? 0 : pause - 1;
			end else begin
				power_bus.ready <= ($urandom_range(0, 15) != 0);
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// Main sequence
	initial begin
		arst_n = 1'b0;
		cfg_bus.valid = 1'b0;
		cfg_bus.index = '0;
		cfg_bus.data = '0;
		operand_bus.valid = 1'b0;
		operand_bus.base_value = '0;
		operand_bus.exponent_value = '0;
		power_bus.ready = 1'b0;
		items_open = 0;
		error_count = 0;
		cycle_count = 0;
		send_calm = 0;
		recv_calm = 0;
		cfg_modulus = 1;
		cfg_iterations = BITS_WIDTH'(OPERAND_WIDTH);
		cfg_r_squared = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// Registers at their reset values
		queue_operation('0, '0);
		queue_operation(ALL_ONES, ALL_ONES);
		wait_idle();

		// Full-width odd modulus: extremes, exponent zero, base at or above modulus
		program_setting(32'hFFFF_FFFB, 32, r_squared(32'hFFFF_FFFB, 32));
		queue_operation('0, '0);
		queue_operation(1, ALL_ONES);
		queue_operation(32'hFFFF_FFFA, 1);
		queue_operation(32'hFFFF_FFFA, 2);
		queue_operation(2, 32'd65537);
		queue_operation(ALL_ONES, 3);
		queue_operation(32'h8000_0000, 32'h8000_0000);
		queue_operation(32'h1234_5678, 32'hFFFF_FFFE);
		wait_idle();

		// Small modulus; a write to the unmapped index must change nothing
		program_setting(32'd211, 8, r_squared(32'd211, 8));
		write_register(REG_UNMAPPED, 32'h0000_0003);
		queue_operation(32'd210, ALL_ONES);
		queue_operation(32'd5, '0);
		queue_operation(ALL_ONES, 32'd7);
		wait_idle();

		// Even modulus with an arbitrary r squared
		program_setting(32'h0000_1000, 13, 32'h0000_0123);
		queue_operation(32'h0000_07FF, 32'd9);
		queue_operation(32'h0000_FFFF, 32'h55);
		wait_idle();

		// Zero iterations
		program_setting(32'd211, 0, 32'd17);
		queue_operation(32'd3, 32'd5);
		queue_operation('0, '0);
		wait_idle();

		// Iteration count above the operand width
		program_setting(ALL_ONES, 63, r_squared(ALL_ONES, 63));
		queue_operation(32'hFFFF_FFFE, ALL_ONES);
		queue_operation(32'd7, 32'd3);
		wait_idle();

		// Zero modulus
		program_setting('0, 32, 32'h5A5A_1234);
		queue_operation(32'h0000_1234, 32'h11);
		queue_operation('0, 32'd2);
		wait_idle();

		// Modulus one, single iteration
		program_setting(32'd1, 1, '0);
		queue_operation('0, 32'd9);
		wait_idle();

		// Random settings and operands
		repeat (6)
			run_random_setting(18);

		wait_idle();
		repeat (20) @(posedge clk);
		if (error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
